>>> rtl/assert_macros.svh
// Assertion macros for the RTL file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define ASSERT_SAME(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/lgs_pkg.sv
// Types, constants and the life rule shared by the grid step block.
package lgs_pkg;

  localparam int ROWS_DEF = 64;
  localparam int COLS_DEF = 32;

  localparam int CMD_W = 2;
  localparam int ROW_W = 6;
  localparam int COL_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  typedef struct packed {
    logic             is_step;
    logic             wr_en;
    logic             wr_val;
    logic [COL_W-1:0] col;
  } head_ctrl_t;

  // Rule B3/S23: born with three neighbors, survives with two or three.
  function automatic logic live_next(input logic self, input logic [3:0] n);
    live_next = (n == 4'd3) || (self && (n == 4'd2));
  endfunction

endpackage

>>> rtl/life_grid_generation_step_top.sv
// Top level of the grid step block: row chain, rule head and command sequencer.
//
// Every command makes one full pass: the grid sits in a chain of ROWS row
// registers that rotates once through the single rule head per command, so
// busy is high during the rotation and the result appears with done in the cycle
// after, when a new item may already be started. A step rewrites each row as
// it passes the head; a write or a read acts when the addressed row passes.
// The result is shown for one cycle only and must be taken then.
module life_grid_generation_step_top import lgs_pkg::*; #(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [CMD_W-1:0] cmd,
  input  logic [ROW_W-1:0] row,
  input  logic [COL_W-1:0] col,
  input  logic             alive_in,
  output logic             busy,
  output logic             done,
  output logic [CMD_W-1:0] done_kind,
  output logic             alive_out
);

`include "assert_macros.svh"

  localparam int CNT_W = $clog2(ROWS);
  localparam int CMP_W = (CNT_W > ROW_W) ? CNT_W : ROW_W;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  cmd_t             cmd_q;
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;
  logic             val_q;
  logic             alive_cap;
  logic [COLS-1:0]  prev_row;
  logic [COLS-1:0]  rows_q [ROWS];
  logic [COLS-1:0]  head_row;
  logic [COLS-1:0]  below;
  logic             head_bit;
  logic             shift;
  logic             last;
  logic             row_hit;
  logic             read_hit;
  head_ctrl_t       ctrl;

  assign busy     = (state == ST_RUN);
  assign shift    = (state == ST_RUN);
  assign last     = (cnt == CNT_W'(ROWS - 1));
  assign row_hit  = (CMP_W'(cnt) == CMP_W'(row_q));
  assign below    = last ? '0 : rows_q[1];
  assign read_hit = (cmd_q == CMD_READ) && row_hit && head_bit;

  assign ctrl.is_step = (cmd_q == CMD_STEP);
  assign ctrl.wr_en   = (cmd_q == CMD_WRITE) && row_hit;
  assign ctrl.wr_val  = val_q;
  assign ctrl.col     = col_q;

  for (genvar i = 0; i < ROWS; i++) begin : g_chain
    if (i == ROWS - 1) begin : g_tail
      lgs_cell #(.COLS(COLS)) u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift),
        .d     (head_row),
        .q     (rows_q[i])
      );
    end else begin : g_body
      lgs_cell #(.COLS(COLS)) u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift),
        .d     (rows_q[i+1]),
        .q     (rows_q[i])
      );
    end
  end

  lgs_head #(.COLS(COLS)) u_head (
    .above    (prev_row),
    .self_row (rows_q[0]),
    .below    (below),
    .ctrl     (ctrl),
    .row_out  (head_row),
    .bit_out  (head_bit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      done      <= 1'b0;
      alive_cap <= 1'b0;
      done_kind <= '0;
      alive_out <= 1'b0;
      cmd_q     <= CMD_NONE;
      row_q     <= '0;
      col_q     <= '0;
      val_q     <= 1'b0;
      prev_row  <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            cmd_q     <= cmd_t'(cmd);
            row_q     <= row;
            col_q     <= col;
            val_q     <= alive_in;
            cnt       <= '0;
            prev_row  <= '0;
            alive_cap <= 1'b0;
            state     <= ST_RUN;
          end
        end
        ST_RUN: begin
          prev_row <= rows_q[0];
          cnt      <= cnt + 1'b1;
          if (read_hit) begin
            alive_cap <= 1'b1;
          end
          if (last) begin
            state     <= ST_IDLE;
            cnt       <= '0;
            done      <= 1'b1;
            done_kind <= cmd_q;
            alive_out <= alive_cap | read_hit;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_SAME(a_done_when_idle, clk, rst, done, !busy)
  `ASSERT_NEXT(a_start_goes_busy, clk, rst, start && !busy, busy)
  `ASSERT_NEXT(a_last_gives_done, clk, rst, busy && last, done && !busy)
  `ASSERT_SAME(a_alive_only_read, clk, rst, done && (done_kind != CMD_READ), !alive_out)

endmodule

>>> rtl/lgs_cell.sv
// One link of the row chain: holds one grid row and loads its input row on a shift.
module lgs_cell import lgs_pkg::*; #(
  parameter int COLS = COLS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  logic [COLS-1:0] d,
  output logic [COLS-1:0] q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

>>> rtl/lgs_head.sv
// Head of the row chain: applies the life rule, a cell write or a cell read to one row.
module lgs_head import lgs_pkg::*; #(
  parameter int COLS = COLS_DEF
) (
  input  logic [COLS-1:0] above,
  input  logic [COLS-1:0] self_row,
  input  logic [COLS-1:0] below,
  input  head_ctrl_t      ctrl,
  output logic [COLS-1:0] row_out,
  output logic            bit_out
);

  logic [COLS+1:0] a_p;
  logic [COLS+1:0] s_p;
  logic [COLS+1:0] b_p;
  logic [COLS-1:0] next_row;
  logic [COLS-1:0] mask;
  logic [COLS-1:0] base;

  assign a_p = {1'b0, above, 1'b0};
  assign s_p = {1'b0, self_row, 1'b0};
  assign b_p = {1'b0, below, 1'b0};

  always_comb begin
    logic [3:0] n;
    n = '0;
    for (int j = 0; j < COLS; j++) begin
      n = 4'(a_p[j]) + 4'(a_p[j+1]) + 4'(a_p[j+2])
        + 4'(s_p[j]) + 4'(s_p[j+2])
        + 4'(b_p[j]) + 4'(b_p[j+1]) + 4'(b_p[j+2]);
      next_row[j] = live_next(self_row[j], n);
      mask[j]     = (int'(ctrl.col) == j);
    end
  end

  assign base    = ctrl.is_step ? next_row : self_row;
  assign row_out = ctrl.wr_en ? ((base & ~mask) | (ctrl.wr_val ? mask : '0)) : base;
  assign bit_out = |(self_row & mask);

endmodule
